/* sv/ilir_pkg.sv */
// Package for the indexed list block: item structs, action and status codes,
// and the per-cell command bundle. Used by ilir_cell and indexed_list_insert_remove.
// No dependencies.
package ilir_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;
  localparam int CNT_OUT_W    = 7;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_SET    = 2'd2,
    ACT_GET    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    action_t                    action;
    logic [POS_W-1:0]           position;
    logic signed [DATA_W-1:0]   value;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0]   read_value;
    status_t                    status;
    logic [CNT_OUT_W-1:0]       element_count;
    logic                       is_empty;
  } out_item_t;

  // Broadcast to every cell; flags are set only for an accepted request with OK status.
  typedef struct packed {
    logic                       ins;
    logic                       rem;
    logic                       set;
    logic                       get;
    logic [POS_W-1:0]           pos;
    logic [DATA_W-1:0]          value;
  } cell_cmd_t;

endpackage

/* sv/ilir_cell.sv */
// One storage cell of the list: holds the entry at index IDX and shifts with
// its neighbors on insert and remove. Depends on ilir_pkg.
module ilir_cell import ilir_pkg::*; #(
  parameter int IDX   = 0,
  parameter int IDX_W = 6
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_data
);

  localparam int CW = (IDX_W > POS_W) ? IDX_W : POS_W;

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic [CW-1:0]     my_idx;
  logic [CW-1:0]     pos_ext;
  logic              hit;

  assign my_idx  = CW'(IDX);
  assign pos_ext = CW'(cmd.pos);
  assign hit     = (my_idx == pos_ext);

  // Insert moves entries at and above the position up by one; remove pulls
  // entries at and above the position down by one.
  always_comb begin
    data_nxt = data_r;
    if (cmd.ins && (my_idx > pos_ext)) begin
      data_nxt = left_data;
    end else if ((cmd.ins || cmd.set) && hit) begin
      data_nxt = cmd.value;
    end else if (cmd.rem && (my_idx >= pos_ext)) begin
      data_nxt = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (cmd.get && hit) ? data_r : '0;

endmodule

/* sv/indexed_list_insert_remove.sv */
// Indexed list top level: request decode, count register, result register
// and a row of ilir_cell storage cells. Depends on ilir_pkg and ilir_cell.
//
// Usage:
// The block keeps an ordered list of up to CAPACITY signed 32-bit words.
// Each request item on the input channel (in_valid, in_stall, in_item)
// inserts, removes, overwrites or reads the entry at a position. Insert
// and remove shift every later entry by one place at once, since
// each entry lives in its own cell that loads from its left or right
// neighbor. Exactly one result item leaves on the output channel
// (out_valid, out_stall, out_item) for every request: the read word, a
// status, the entry count after the request and an empty flag.
// The result is valid in the cycle after the request is accepted, and a
// new item can be accepted every cycle; the single result register is the
// only limit, so throughput is one item per cycle while the receiver drains.
// When the receiver stalls, the result register holds its item and
// in_stall rises, so no further item is taken until the result leaves.
// Reset clears the count and the result valid flag; the result payload and
// the cell contents are not cleared, as only entries below the count can
// ever be read.
module indexed_list_insert_remove import ilir_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  out_item_t         out_item_r;
  out_item_t         out_item_nxt;

  logic              accept;
  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic              pos_in_list;
  logic              pos_le_count;
  logic              is_full;
  status_t           status;
  cell_cmd_t         cmd;
  logic [DATA_W-1:0] read_word;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];

  // The result register is free when it is empty or being taken this cycle.
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  assign pos_c        = CMP_W'(in_item.position);
  assign cnt_c        = CMP_W'(count_r);
  assign pos_in_list  = (pos_c < cnt_c);
  assign pos_le_count = (pos_c <= cnt_c);
  assign is_full      = (count_r == CNT_W'(CAPACITY));

  // The range check on insert comes before the full check.
  always_comb begin
    status = ST_OK;
    case (in_item.action)
      ACT_INSERT: begin
        if (!pos_le_count) begin
          status = ST_RANGE;
        end else if (is_full) begin
          status = ST_FULL;
        end
      end
      ACT_REMOVE, ACT_SET, ACT_GET: begin
        if (!pos_in_list) begin
          status = ST_RANGE;
        end
      end
      default: begin
        status = ST_RANGE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    cmd.pos   = in_item.position;
    cmd.value = in_item.value;
    if (accept && (status == ST_OK)) begin
      cmd.ins = (in_item.action == ACT_INSERT);
      cmd.rem = (in_item.action == ACT_REMOVE);
      cmd.set = (in_item.action == ACT_SET);
      cmd.get = (in_item.action == ACT_GET);
    end
  end

  // Row of cells; each one sees its two neighbors. The first cell never
  // loads from the left, and the last one holds on remove.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_w;
    logic [DATA_W-1:0] right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_mid_l
      assign left_w = cell_data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = cell_data[i];
    end else begin : g_mid_r
      assign right_w = cell_data[i+1];
    end

    ilir_cell #(
      .IDX   (i),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  (left_w),
      .right_data (right_w),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  // Only the addressed cell drives a nonzero word, so an OR collects it.
  always_comb begin
    read_word = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      read_word = read_word | cell_rd[k];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.rem) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    if (accept) begin
      out_valid_nxt              = 1'b1;
      out_item_nxt.read_value    = read_word;
      out_item_nxt.status        = status;
      out_item_nxt.element_count = CNT_OUT_W'(count_nxt);
      out_item_nxt.is_empty      = (count_nxt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r <= out_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // The count never passes the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // Every accepted item leaves a result in the register on the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted item produced no result");

  // A successful insert grows the count by exactly one.
  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the count by one");

  // A full status is reported only when the list was at capacity.
  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (status == ST_FULL)) |-> is_full)
    else $error("full status without a full list");

endmodule
